/* rtl/modular_exponentiation_core_macros.svh */
// assertion macros used by the checker file
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MEXP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// next-cycle implication, disabled while reset is low
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

/* rtl/mexp_pkg.sv */
// shared constants, control word types and microcode rom of the exponentiation core
`default_nettype none

package mexp_pkg;

  // operand width and derived widths
  localparam int unsigned VALUE_BITS = 63;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned PC_W       = 4;

  // datapath actions driven by the control word
  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_RED_GO,
    A_RED_WB,
    A_EXP_GO,
    A_EXP_WB,
    A_OUT_OK,
    A_OUT_ERR
  } act_e;

  // sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_START,
    C_MZERO,
    C_EZERO,
    C_DONE,
    C_JUMP
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    act_e act;
  } dp_ctrl_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic mul_done;
  } dp_flags_t;

  // microcode addresses
  localparam logic [PC_W-1:0] UA_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] UA_CHK_MOD = 4'd1;
  localparam logic [PC_W-1:0] UA_RED_GO  = 4'd2;
  localparam logic [PC_W-1:0] UA_RED_WB  = 4'd3;
  localparam logic [PC_W-1:0] UA_LOOP    = 4'd4;
  localparam logic [PC_W-1:0] UA_EXP_GO  = 4'd5;
  localparam logic [PC_W-1:0] UA_EXP_WB  = 4'd6;
  localparam logic [PC_W-1:0] UA_OUT_ERR = 4'd7;
  localparam logic [PC_W-1:0] UA_OUT_OK  = 4'd8;

  // the control program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    case (addr)
      UA_IDLE:    w = '{act: A_LOAD,    cond: C_START, target: UA_CHK_MOD};
      UA_CHK_MOD: w = '{act: A_NONE,    cond: C_MZERO, target: UA_OUT_ERR};
      UA_RED_GO:  w = '{act: A_RED_GO,  cond: C_NEXT,  target: UA_IDLE};
      UA_RED_WB:  w = '{act: A_RED_WB,  cond: C_DONE,  target: UA_LOOP};
      UA_LOOP:    w = '{act: A_NONE,    cond: C_EZERO, target: UA_OUT_OK};
      UA_EXP_GO:  w = '{act: A_EXP_GO,  cond: C_NEXT,  target: UA_IDLE};
      UA_EXP_WB:  w = '{act: A_EXP_WB,  cond: C_DONE,  target: UA_LOOP};
      UA_OUT_ERR: w = '{act: A_OUT_ERR, cond: C_JUMP,  target: UA_IDLE};
      UA_OUT_OK:  w = '{act: A_OUT_OK,  cond: C_JUMP,  target: UA_IDLE};
      default:    w = '{act: A_NONE,    cond: C_JUMP,  target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/modular_exponentiation_core.sv */
// top level of the modular exponentiation core
//
// channel   direction  handshake            payload
// command   in         start && !busy       base_value_i, exponent_i, modulus_i
// result    out        done_o, one cycle    power_result_o, modulus_error_o
//
// zero modulus: the modulus check goes straight to the error word, with no multiplier pass.
// otherwise each exponent bit, up to the bit length of the exponent, costs one pass
// of the bit-serial multipliers (square and multiply run side by side), plus the
// base reduction pass.
// one command at a time; busy is low again in the cycle the result word shows.
// asynchronous active-low reset returns the sequencer to idle and drops done_o.
// the receiver cannot stall: the result word is valid for one cycle only.
`default_nettype none

module modular_exponentiation_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] base_value_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] exponent_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] modulus_i,
  output logic                                 done_o,
  output logic [mexp_pkg::VALUE_BITS-1:0]      power_result_o,
  output logic                                 modulus_error_o
);
  import mexp_pkg::*;

  dp_ctrl_t  ctrl;
  dp_flags_t flags;

  // control program
  mexp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // arithmetic
  mexp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .base_value_i    (base_value_i),
    .exponent_i      (exponent_i),
    .modulus_i       (modulus_i),
    .flags_o         (flags),
    .done_o          (done_o),
    .power_result_o  (power_result_o),
    .modulus_error_o (modulus_error_o)
  );

endmodule

`default_nettype wire

/* rtl/mexp_mulred.sv */
// bit-serial modular multiplier: one multiplier bit per cycle, msb first
`default_nettype none

module mexp_mulred (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           go_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] a_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] b_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] m_i,
  output logic                                done_o,
  output logic [mexp_pkg::VALUE_BITS-1:0]     prod_o
);
  import mexp_pkg::*;

  localparam int unsigned W = VALUE_BITS;

  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     a_q, b_q, m_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic             last;
  logic [W:0]       dbl, mod_ext, sum;
  logic [W-1:0]     red1;

  assign last    = (cnt_q == CNT_W'(W - 1));
  assign mod_ext = {1'b0, m_q};

  // double and reduce, then add the partial product and reduce
  always_comb begin
    dbl = {acc_q, 1'b0};
    if (dbl >= mod_ext) begin
      red1 = W'(dbl - mod_ext);
    end else begin
      red1 = dbl[W-1:0];
    end
    sum = {1'b0, red1} + (b_q[W-1] ? {1'b0, a_q} : '0);
    if (sum >= mod_ext) begin
      acc_d = W'(sum - mod_ext);
    end else begin
      acc_d = sum[W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && last;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // operand and accumulator words
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* rtl/mexp_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module mexp_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire mexp_pkg::dp_flags_t flags_i,
  output mexp_pkg::dp_ctrl_t       ctrl_o,
  output logic                     busy_o
);
  import mexp_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;

  assign uw = ucode_rom(pc_q);

  // next step
  always_comb begin
    pc_d = pc_q;
    case (uw.cond)
      C_NEXT:  pc_d = pc_q + 1'b1;
      C_START: pc_d = start_i ? uw.target : pc_q;
      C_MZERO: pc_d = flags_i.m_zero ? uw.target : pc_q + 1'b1;
      C_EZERO: pc_d = flags_i.e_zero ? uw.target : pc_q + 1'b1;
      C_DONE:  pc_d = flags_i.mul_done ? uw.target : pc_q;
      C_JUMP:  pc_d = uw.target;
      default: pc_d = UA_IDLE;
    endcase
  end

  // control word out; operand load only on a start
  always_comb begin
    ctrl_o.act = uw.act;
    if (uw.act == A_LOAD && !start_i) begin
      ctrl_o.act = A_NONE;
    end
  end

  assign busy_o = (pc_q != UA_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mexp_datapath.sv */
// operand registers, two modular multipliers and the result register
`default_nettype none

module mexp_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mexp_pkg::dp_ctrl_t              ctrl_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] base_value_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] exponent_i,
  input  wire logic [mexp_pkg::VALUE_BITS-1:0] modulus_i,
  output mexp_pkg::dp_flags_t                  flags_o,
  output logic                                 done_o,
  output logic [mexp_pkg::VALUE_BITS-1:0]      power_result_o,
  output logic                                 modulus_error_o
);
  import mexp_pkg::*;

  localparam int unsigned W = VALUE_BITS;

  logic [W-1:0] base_q, exp_q, mod_q, acc_q;
  logic [W-1:0] mul_a_op;
  logic [W-1:0] prod_a, prod_b;
  logic         go_a, go_b, done_a, done_b;
  logic         strobe_q;
  logic [W-1:0] power_q;
  logic         err_q;

  // unit a reduces the base or multiplies the accumulator, unit b squares
  assign go_a     = (ctrl_i.act == A_RED_GO) || (ctrl_i.act == A_EXP_GO);
  assign go_b     = (ctrl_i.act == A_EXP_GO);
  assign mul_a_op = (ctrl_i.act == A_RED_GO) ? W'(1) : acc_q;

  mexp_mulred u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_a),
    .a_i    (mul_a_op),
    .b_i    (base_q),
    .m_i    (mod_q),
    .done_o (done_a),
    .prod_o (prod_a)
  );

  mexp_mulred u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_b),
    .a_i    (base_q),
    .b_i    (base_q),
    .m_i    (mod_q),
    .done_o (done_b),
    .prod_o (prod_b)
  );

  // status to the sequencer; both units finish on the same cycle
  assign flags_o.m_zero   = (mod_q == '0);
  assign flags_o.e_zero   = (exp_q == '0);
  assign flags_o.mul_done = done_a;

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      A_LOAD: begin
        base_q <= base_value_i;
        exp_q  <= exponent_i;
        mod_q  <= modulus_i;
        acc_q  <= W'(1);
      end
      A_RED_WB: begin
        if (done_a) begin
          base_q <= prod_a;
        end
      end
      A_EXP_WB: begin
        if (done_a && done_b) begin
          if (exp_q[0]) begin
            acc_q <= prod_a;
          end
          base_q <= prod_b;
          exp_q  <= {1'b0, exp_q[W-1:1]};
        end
      end
      default: begin
      end
    endcase
  end

  // result word strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (ctrl_i.act == A_OUT_OK) || (ctrl_i.act == A_OUT_ERR);
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == A_OUT_OK) begin
      power_q <= acc_q;
      err_q   <= 1'b0;
    end else if (ctrl_i.act == A_OUT_ERR) begin
      power_q <= '0;
      err_q   <= 1'b1;
    end
  end

  assign done_o          = strobe_q;
  assign power_result_o  = power_q;
  assign modulus_error_o = err_q;

endmodule

`default_nettype wire

/* rtl/mexp_checker.sv */
// port-level checker for the exponentiation core, bound to the top level
`default_nettype none

`include "modular_exponentiation_core_macros.svh"

module mexp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [mexp_pkg::VALUE_BITS-1:0] modulus_i,
  input wire logic                            done_o,
  input wire logic [mexp_pkg::VALUE_BITS-1:0] power_result_o,
  input wire logic                            modulus_error_o
);
  import mexp_pkg::*;

  logic zero_mod_take;

  // command taken with a zero modulus
  assign zero_mod_take = start && !busy && (modulus_i == '0);

  // a taken command makes the core busy
  `MEXP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // result words never come back to back
  `MEXP_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)

  // an error word carries a zero result
  `MEXP_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && modulus_error_o, power_result_o == '0)

  // zero modulus gives the error word on the fixed short path
  `MEXP_ASSERT_NEXT(a_zero_mod_path, clk_i, rst_ni, zero_mod_take, ##2 (done_o && modulus_error_o))

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .modulus_i       (modulus_i),
  .done_o          (done_o),
  .power_result_o  (power_result_o),
  .modulus_error_o (modulus_error_o)
);

`default_nettype wire
